### rtl/core/aga_pkg.sv
// ----------------------------------------------------------------------------
// aga_pkg
// Types and constants shared by the gain ramp controller, datapath and units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aga_pkg;

    localparam int EXT_EXTRA = 16;
    localparam int GAIN_W    = 48;
    localparam int STEP_W    = 57;

    localparam logic [63:0] Q32_ONE      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] POW_CAP      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] GAIN_MAX_CAP = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [56:0] BS_HI_INIT   = 57'h100_0000_0000_0000;

    typedef enum logic [1:0] {
        KIND_CONST,
        KIND_LIN,
        KIND_EXP
    } kind_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SET_CONST,
        CMD_DIV_LIN,
        CMD_DIV_EXP,
        CMD_SET_LIN,
        CMD_SET_T,
        CMD_BS_MID,
        CMD_BS_DECIDE,
        CMD_BS_FINISH,
        CMD_MUL_RES,
        CMD_MUL_BASE,
        CMD_MUL_EXP,
        CMD_MUL_OUT,
        CMD_WRITE_OUT
    } cmd_t;

    typedef enum logic [1:0] {
        DST_RES,
        DST_BASE,
        DST_GAIN,
        DST_OUT
    } mul_dst_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_LIN,
        ST_DIV_EXP,
        ST_BS_TEST,
        ST_POW_BIT,
        ST_RES_WAIT,
        ST_BASE_START,
        ST_BASE_WAIT,
        ST_PREP,
        ST_EXP_WAIT,
        ST_OUT_START,
        ST_OUT_WAIT,
        ST_OUT_WRITE
    } state_t;

    typedef struct packed {
        logic restart;
        logic same_gain;
        logic exp_ok;
        logic div_done;
        logic mul_done;
        logic bs_go;
        logic nn_zero;
        logic nn_odd;
        logic kind_exp;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/aga_mul.sv
// ----------------------------------------------------------------------------
// aga_mul
// 64x64 unsigned multiply over four 32x32 partial products, then a right
// shift and a saturating compare against a cap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aga_mul
    import aga_pkg::*;
#(
    parameter int EXT_FRAC = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] x,
    input  wire logic [63:0] y,
    input  wire logic        use_ext,
    input  wire logic [63:0] cap,
    output logic             done,
    output logic [63:0]      result,
    output logic             sat
);

    logic          run_reg, run_next;
    logic [2:0]    count_reg, count_next;
    logic [63:0]   x_reg, y_reg, cap_reg;
    logic          ext_reg;
    logic [63:0]   pp_reg, pp_next;
    logic [127:0]  acc_reg, acc_next;
    logic [127:0]  add_term, shifted;
    logic [31:0]   xs, ys;
    logic          done_reg, done_next;
    logic [63:0]   result_reg;
    logic          sat_reg;
    logic          sat_cmp;

    always_comb begin
        case (count_reg[1:0])
            2'd0: begin xs = x_reg[31:0];  ys = y_reg[31:0];  end
            2'd1: begin xs = x_reg[31:0];  ys = y_reg[63:32]; end
            2'd2: begin xs = x_reg[63:32]; ys = y_reg[31:0];  end
            default: begin xs = x_reg[63:32]; ys = y_reg[63:32]; end
        endcase
        pp_next = 64'(xs) * 64'(ys);
        case (count_reg)
            3'd1:       add_term = {64'b0, pp_reg};
            3'd2, 3'd3: add_term = {32'b0, pp_reg, 32'b0};
            3'd4:       add_term = {pp_reg, 64'b0};
            default:    add_term = '0;
        endcase
        acc_next = acc_reg + add_term;
        shifted  = ext_reg ? (acc_reg >> EXT_FRAC) : (acc_reg >> 32);
        sat_cmp  = shifted > {64'b0, cap_reg};
        run_next   = run_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        if (run_reg) begin
            count_next = count_reg + 3'd1;
            if (count_reg == 3'd5) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start) begin
            run_next   = 1'b1;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            run_reg   <= run_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x;
            y_reg   <= y;
            cap_reg <= cap;
            ext_reg <= use_ext;
            acc_reg <= '0;
        end else if (run_reg) begin
            if (count_reg < 3'd4) begin
                pp_reg <= pp_next;
            end
            acc_reg <= acc_next;
            if (count_reg == 3'd5) begin
                result_reg <= sat_cmp ? cap_reg : shifted[63:0];
                sat_reg    <= sat_cmp;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

`default_nettype wire

### rtl/core/aga_div.sv
// ----------------------------------------------------------------------------
// aga_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend over a
// 24-bit divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aga_div
    import aga_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             done,
    output logic [63:0]      quotient
);

    logic        run_reg, run_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [23:0] rem_reg, dvs_reg;
    logic [63:0] q_reg;
    logic [24:0] rem_sh, rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[63]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = rem_sh >= {1'b0, dvs_reg};
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (run_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            rem_reg <= ge ? rem_sub[23:0] : rem_sh[23:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

### rtl/core/aga_dp.sv
// ----------------------------------------------------------------------------
// aga_dp
// Gain ramp datapath: input latch, ramp state, ratio search registers,
// shared multiplier and divider, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aga_dp
    import aga_pkg::*;
#(
    parameter int MAX_CHUNK      = 4096,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output dp_status_t              status,
    input  wire logic signed [31:0] s_sample,
    input  wire logic signed [23:0] s_start_gain,
    input  wire logic signed [23:0] s_end_gain,
    input  wire logic [12:0]        s_chunk_length,
    input  wire logic               s_restart,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_scaled_sample,
    output logic                    m_clipped,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);

    localparam int EXT_FRAC = GAIN_FRAC_BITS + EXT_EXTRA;

    logic               exp_ramp_reg;
    logic signed [31:0] sample_reg;
    logic signed [23:0] a_reg, b_reg;
    logic [12:0]        n_reg, n_clamped;
    logic               restart_reg;

    logic signed [GAIN_W-1:0] cg_reg;
    logic signed [STEP_W-1:0] step_reg;
    kind_t                    kind_reg;

    logic [63:0] t_reg, res_reg, base_reg;
    logic [56:0] lo_reg, hi_reg, mid_reg, span;
    logic [12:0] nn_reg;
    mul_dst_t    dst_reg;

    logic               m_valid_reg;
    logic signed [31:0] out_reg;
    logic               clip_reg;

    logic [24:0] a_ext, b_ext, d_ext, mag_a, mag_b, mag_d;
    logic [GAIN_W-1:0] mag_cg;
    logic [31:0] mag_s;
    logic        out_neg;
    logic [57:0] lin_sum;
    logic [GAIN_W-1:0] lin_clamped;
    logic [STEP_W-1:0] lin_q;

    logic        mul_start, mul_ext, mul_done, mul_sat;
    logic [63:0] mul_x, mul_y, mul_cap, mul_res;
    logic        div_start, div_done;
    logic [63:0] div_dvd, div_q;
    logic [23:0] div_dvs;

    always_comb begin
        if (s_chunk_length == 13'd0) begin
            n_clamped = 13'd1;
        end else if (32'(s_chunk_length) > 32'(MAX_CHUNK)) begin
            n_clamped = 13'(MAX_CHUNK);
        end else begin
            n_clamped = s_chunk_length;
        end
    end

    always_comb begin
        a_ext  = {a_reg[23], a_reg};
        b_ext  = {b_reg[23], b_reg};
        d_ext  = b_ext - a_ext;
        mag_a  = a_reg[23] ? -a_ext : a_ext;
        mag_b  = b_reg[23] ? -b_ext : b_ext;
        mag_d  = d_ext[24] ? -d_ext : d_ext;
        mag_cg = cg_reg[GAIN_W-1] ? -cg_reg : cg_reg;
        mag_s  = sample_reg[31] ? -sample_reg : sample_reg;
        out_neg = sample_reg[31] ^ cg_reg[GAIN_W-1];
        span   = hi_reg - lo_reg;
        lin_q  = {16'b0, div_q[40:0]};
        lin_sum = {{10{cg_reg[GAIN_W-1]}}, cg_reg} + {step_reg[STEP_W-1], step_reg};
        if ($signed(lin_sum) > $signed({10'b0, GAIN_MAX_CAP[47:0]})) begin
            lin_clamped = GAIN_MAX_CAP[47:0];
        end else if ($signed(lin_sum) < -$signed({10'b0, GAIN_MAX_CAP[47:0]})) begin
            lin_clamped = -GAIN_MAX_CAP[47:0];
        end else begin
            lin_clamped = lin_sum[47:0];
        end
    end

    always_comb begin
        status.restart   = restart_reg;
        status.same_gain = a_reg == b_reg;
        status.exp_ok    = exp_ramp_reg && (a_reg[23] == b_reg[23]) &&
                           (a_reg != 24'sd0) && (b_reg != 24'sd0);
        status.div_done  = div_done;
        status.mul_done  = mul_done;
        status.bs_go     = span > 57'd1;
        status.nn_zero   = nn_reg == 13'd0;
        status.nn_odd    = nn_reg[0];
        status.kind_exp  = kind_reg == KIND_EXP;
        status.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        mul_start = 1'b0;
        mul_x     = res_reg;
        mul_y     = base_reg;
        mul_ext   = 1'b0;
        mul_cap   = POW_CAP;
        div_start = 1'b0;
        div_dvd   = {23'b0, mag_d, 16'b0};
        div_dvs   = {11'b0, n_reg};
        case (cmd)
            CMD_MUL_RES: begin
                mul_start = 1'b1;
            end
            CMD_MUL_BASE: begin
                mul_start = 1'b1;
                mul_x     = base_reg;
            end
            CMD_MUL_EXP: begin
                mul_start = 1'b1;
                mul_x     = {16'b0, mag_cg};
                mul_y     = {7'b0, step_reg};
                mul_cap   = GAIN_MAX_CAP;
            end
            CMD_MUL_OUT: begin
                mul_start = 1'b1;
                mul_x     = {32'b0, mag_s};
                mul_y     = {16'b0, mag_cg};
                mul_ext   = 1'b1;
                mul_cap   = out_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            end
            CMD_DIV_LIN: begin
                div_start = 1'b1;
            end
            CMD_DIV_EXP: begin
                div_start = 1'b1;
                div_dvd   = {7'b0, mag_b, 32'b0};
                div_dvs   = mag_a[23:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ramp_reg <= 1'b0;
        end else if (cfg_valid) begin
            exp_ramp_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cg_reg      <= '0;
            step_reg    <= '0;
            kind_reg    <= KIND_CONST;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_done && dst_reg == DST_GAIN) begin
                cg_reg <= cg_reg[GAIN_W-1] ? -mul_res[47:0] : mul_res[47:0];
            end
            case (cmd)
                CMD_SET_CONST, CMD_DIV_LIN, CMD_DIV_EXP: begin
                    cg_reg <= {{8{a_reg[23]}}, a_reg, 16'b0};
                    if (cmd == CMD_SET_CONST) begin
                        step_reg <= '0;
                        kind_reg <= KIND_CONST;
                    end
                end
                CMD_SET_LIN: begin
                    step_reg <= d_ext[24] ? -lin_q : lin_q;
                    kind_reg <= KIND_LIN;
                end
                CMD_BS_FINISH: begin
                    step_reg <= lo_reg;
                    kind_reg <= KIND_EXP;
                end
                CMD_WRITE_OUT: begin
                    m_valid_reg <= 1'b1;
                    if (kind_reg == KIND_LIN) begin
                        cg_reg <= lin_clamped;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_done) begin
            case (dst_reg)
                DST_RES:  res_reg <= mul_res;
                DST_BASE: begin
                    base_reg <= mul_res;
                    nn_reg   <= nn_reg >> 1;
                end
                default: begin
                end
            endcase
        end
        case (cmd)
            CMD_LOAD: begin
                sample_reg  <= s_sample;
                a_reg       <= s_start_gain;
                b_reg       <= s_end_gain;
                n_reg       <= n_clamped;
                restart_reg <= s_restart;
            end
            CMD_SET_T: begin
                t_reg  <= div_q;
                lo_reg <= '0;
                hi_reg <= BS_HI_INIT;
            end
            CMD_BS_MID: begin
                mid_reg  <= lo_reg + (span >> 1);
                base_reg <= {7'b0, lo_reg + (span >> 1)};
                res_reg  <= Q32_ONE;
                nn_reg   <= n_reg;
            end
            CMD_BS_DECIDE: begin
                if (res_reg <= t_reg) begin
                    lo_reg <= mid_reg;
                end else begin
                    hi_reg <= mid_reg;
                end
            end
            CMD_MUL_RES:  dst_reg <= DST_RES;
            CMD_MUL_BASE: dst_reg <= DST_BASE;
            CMD_MUL_EXP:  dst_reg <= DST_GAIN;
            CMD_MUL_OUT:  dst_reg <= DST_OUT;
            CMD_WRITE_OUT: begin
                out_reg  <= out_neg ? -mul_res[31:0] : mul_res[31:0];
                clip_reg <= mul_sat;
            end
            default: begin
            end
        endcase
    end

    aga_mul #(
        .EXT_FRAC (EXT_FRAC)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .use_ext (mul_ext),
        .cap     (mul_cap),
        .done    (mul_done),
        .result  (mul_res),
        .sat     (mul_sat)
    );

    aga_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid         = m_valid_reg;
    assign m_scaled_sample = out_reg;
    assign m_clipped       = clip_reg;
    assign cfg_ready       = 1'b1;

endmodule

`default_nettype wire

### rtl/core/aga_ctrl.sv
// ----------------------------------------------------------------------------
// aga_ctrl
// Sequencer for ramp setup, ratio search, gain update and output write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aga_ctrl
    import aga_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output cmd_t            cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_valid) state_next = ST_SETUP;
            ST_SETUP: begin
                if (!status.restart || status.same_gain) begin
                    state_next = ST_PREP;
                end else if (status.exp_ok) begin
                    state_next = ST_DIV_EXP;
                end else begin
                    state_next = ST_DIV_LIN;
                end
            end
            ST_DIV_LIN:    if (status.div_done) state_next = ST_PREP;
            ST_DIV_EXP:    if (status.div_done) state_next = ST_BS_TEST;
            ST_BS_TEST:    state_next = status.bs_go ? ST_POW_BIT : ST_PREP;
            ST_POW_BIT: begin
                if (status.nn_zero) begin
                    state_next = ST_BS_TEST;
                end else if (status.nn_odd) begin
                    state_next = ST_RES_WAIT;
                end else begin
                    state_next = ST_BASE_START;
                end
            end
            ST_RES_WAIT:   if (status.mul_done) state_next = ST_BASE_START;
            ST_BASE_START: state_next = ST_BASE_WAIT;
            ST_BASE_WAIT:  if (status.mul_done) state_next = ST_POW_BIT;
            ST_PREP:       state_next = status.kind_exp ? ST_EXP_WAIT : ST_OUT_START;
            ST_EXP_WAIT:   if (status.mul_done) state_next = ST_OUT_START;
            ST_OUT_START:  state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:   if (status.mul_done) state_next = ST_OUT_WRITE;
            ST_OUT_WRITE:  if (status.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = CMD_NONE;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd = CMD_LOAD;
            end
            ST_SETUP: begin
                if (status.restart) begin
                    if (status.same_gain) begin
                        cmd = CMD_SET_CONST;
                    end else if (status.exp_ok) begin
                        cmd = CMD_DIV_EXP;
                    end else begin
                        cmd = CMD_DIV_LIN;
                    end
                end
            end
            ST_DIV_LIN:    if (status.div_done) cmd = CMD_SET_LIN;
            ST_DIV_EXP:    if (status.div_done) cmd = CMD_SET_T;
            ST_BS_TEST:    cmd = status.bs_go ? CMD_BS_MID : CMD_BS_FINISH;
            ST_POW_BIT: begin
                if (status.nn_zero) begin
                    cmd = CMD_BS_DECIDE;
                end else if (status.nn_odd) begin
                    cmd = CMD_MUL_RES;
                end
            end
            ST_BASE_START: cmd = CMD_MUL_BASE;
            ST_PREP:       if (status.kind_exp) cmd = CMD_MUL_EXP;
            ST_OUT_START:  cmd = CMD_MUL_OUT;
            ST_OUT_WRITE:  if (status.out_free) cmd = CMD_WRITE_OUT;
            ST_RES_WAIT, ST_BASE_WAIT, ST_EXP_WAIT, ST_OUT_WAIT: begin
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/audio_gain_ramp.sv
// ----------------------------------------------------------------------------
// audio_gain_ramp
// Scales each audio sample by a constant, linear or exponential gain ramp.
//
// s_ channel: one request per sample; s_restart loads a new ramp from
// s_start_gain, s_end_gain and s_chunk_length and the exp_ramp register.
// m_ channel: one scaled sample per request, with a saturation flag.
// cfg channel: one-bit exp_ramp register, always ready, write while idle.
// One request is in flight at a time. Sample timing is set by the shared
// 64x64 multiplier, which an exponential ramp also uses for the gain update.
// A linear restart adds the divider; an exponential restart adds the divider
// and a 56-step ratio search, each step a square-and-multiply over the chunk
// length bits. The output register holds a result until m_ready; the next
// request is taken while it waits, and the block stalls only if a second
// result is ready before the first is taken. Reset clears the ramp to a
// constant zero gain and the register to linear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module audio_gain_ramp
    import aga_pkg::*;
#(
    parameter int MAX_CHUNK      = 4096,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_sample,
    input  wire logic signed [23:0] s_start_gain,
    input  wire logic signed [23:0] s_end_gain,
    input  wire logic [12:0]        s_chunk_length,
    input  wire logic               s_restart,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_scaled_sample,
    output logic                    m_clipped,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);

    cmd_t       cmd;
    dp_status_t status;

    aga_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    aga_dp #(
        .MAX_CHUNK      (MAX_CHUNK),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_sample        (s_sample),
        .s_start_gain    (s_start_gain),
        .s_end_gain      (s_end_gain),
        .s_chunk_length  (s_chunk_length),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scaled_sample (m_scaled_sample),
        .m_clipped       (m_clipped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

endmodule

`default_nettype wire
